FILE: design/utf8d_pkg.sv
// shared types and constants for the utf-8 byte stream decoder
package utf8d_pkg;

  localparam logic [31:0] SUBST_CP  = 32'h0000_FFFD;
  localparam int          CONT_BITS = 6;
  localparam int          ACC_W     = 32;

  typedef struct packed {
    logic [31:0] code_point;
    logic        is_replacement;
    logic        run_last;
  } result_t;

  typedef struct packed {
    logic [1:0]       count;
    result_t          r0;
    result_t          r1;
    logic [2:0]       need_next;
    logic [ACC_W-1:0] acc_next;
  } decode_out_t;

endpackage

FILE: design/utf8d_if.sv
// byte and code point channel interfaces
interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface utf8d_cp_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_point;
  logic        is_replacement;
  logic        run_last;

  modport source (output valid, output code_point, output is_replacement,
                  output run_last, input ready);
  modport sink (input valid, input code_point, input is_replacement,
                input run_last, output ready);
endinterface

FILE: design/utf8d_decode.sv
// combinational decode of one byte against the sequence state
module utf8d_decode (
  input  logic [7:0]                byte_in,
  input  logic                      last_byte,
  input  logic [2:0]                need,
  input  logic [utf8d_pkg::ACC_W-1:0] acc,
  output utf8d_pkg::decode_out_t    dec
);

  logic [2:0]  lead_n;
  logic [7:0]  lead_payload;
  logic        is_cont;
  logic        f_emit;
  logic        f_load;
  logic [2:0]  f_need;
  logic [31:0] f_cp;
  logic        f_repl;
  logic [utf8d_pkg::ACC_W-1:0] acc_sh;
  logic [2:0]  need_dec;

  always_comb begin
    case (byte_in) inside
      8'b1111_1111: lead_n = 3'd7;
      8'b1111_1110: lead_n = 3'd6;
      8'b1111_110?: lead_n = 3'd5;
      8'b1111_10??: lead_n = 3'd4;
      8'b1111_0???: lead_n = 3'd3;
      8'b1110_????: lead_n = 3'd2;
      default:      lead_n = 3'd1;
    endcase
  end

  assign lead_payload = byte_in & (8'hFF >> ({1'b0, lead_n} + 4'd1));
  assign is_cont      = (byte_in[7:6] == 2'b10);
  assign acc_sh       = {acc[utf8d_pkg::ACC_W-utf8d_pkg::CONT_BITS-1:0],
                         byte_in[utf8d_pkg::CONT_BITS-1:0]};
  assign need_dec     = need - 3'd1;

  // byte seen with no sequence open
  always_comb begin
    f_emit = 1'b0;
    f_load = 1'b0;
    f_need = 3'd0;
    f_cp   = utf8d_pkg::SUBST_CP;
    f_repl = 1'b1;
    if (byte_in[7] == 1'b0) begin
      f_emit = 1'b1;
      f_cp   = {24'd0, byte_in};
      f_repl = 1'b0;
    end else if (byte_in[6] == 1'b0) begin
      f_emit = last_byte;
    end else begin
      f_load = 1'b1;
      f_emit = last_byte;
      f_need = last_byte ? 3'd0 : lead_n;
    end
  end

  always_comb begin
    dec          = '0;
    dec.need_next = need;
    dec.acc_next  = acc;
    if (need != 3'd0) begin
      if (is_cont) begin
        dec.acc_next = acc_sh;
        if (need_dec == 3'd0) begin
          dec.count         = 2'd1;
          dec.r0.code_point = acc_sh;
          dec.need_next     = 3'd0;
        end else if (last_byte) begin
          dec.count             = 2'd1;
          dec.r0.code_point     = utf8d_pkg::SUBST_CP;
          dec.r0.is_replacement = 1'b1;
          dec.need_next         = 3'd0;
        end else begin
          dec.need_next = need_dec;
        end
      end else begin
        // broken sequence, then the byte is handled afresh
        dec.r0.code_point     = utf8d_pkg::SUBST_CP;
        dec.r0.is_replacement = 1'b1;
        dec.r1.code_point     = f_cp;
        dec.r1.is_replacement = f_repl;
        dec.count             = f_emit ? 2'd2 : 2'd1;
        dec.need_next         = f_need;
        if (f_load) begin
          dec.acc_next = {24'd0, lead_payload};
        end
      end
    end else begin
      dec.r0.code_point     = f_cp;
      dec.r0.is_replacement = f_repl;
      dec.count             = f_emit ? 2'd1 : 2'd0;
      dec.need_next         = f_need;
      if (f_load) begin
        dec.acc_next = {24'd0, lead_payload};
      end
    end
    if (last_byte) begin
      dec.need_next = 3'd0;
    end
    dec.r0.run_last = (dec.count == 2'd1);
    dec.r1.run_last = 1'b1;
  end

endmodule

FILE: design/utf8d_result_buf.sv
// two-entry result register that drains one code point per cycle while the receiver is ready
module utf8d_result_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [1:0]           count,
  input  utf8d_pkg::result_t   r0,
  input  utf8d_pkg::result_t   r1,
  output logic                 can_load,
  utf8d_cp_if.source           code_points
);

  logic [1:0]         cnt;
  logic [1:0]         cnt_next;
  logic               pop;
  logic               take;
  utf8d_pkg::result_t slot0;
  utf8d_pkg::result_t slot1;

  assign pop      = (cnt != 2'd0) && code_points.ready;
  assign can_load = (cnt == 2'd0) || ((cnt == 2'd1) && code_points.ready);
  assign take     = load && can_load;

  always_comb begin
    if (take) begin
      cnt_next = count;
    end else if (pop) begin
      cnt_next = cnt - 2'd1;
    end else begin
      cnt_next = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot0 <= r0;
      slot1 <= r1;
    end else if (pop && (cnt == 2'd2)) begin
      slot0 <= slot1;
    end
  end

  assign code_points.valid          = (cnt != 2'd0);
  assign code_points.code_point     = slot0.code_point;
  assign code_points.is_replacement = slot0.is_replacement;
  assign code_points.run_last       = slot0.run_last;

endmodule

FILE: design/utf8_byte_stream_decoder_top.sv
// utf-8 byte stream decoder top level
//
//   channel       dir  payload
//   bytes         in   byte_in[7:0], last_byte
//   code_points   out  code_point[31:0], is_replacement, run_last
//
// one byte per cycle while each byte gives at most one code point and the
// receiver takes every code point; a byte that gives two code points holds
// the input while the first of them drains through the single output port
// of the two-entry result register.
// the first code point of a byte passes the input and result registers.
// rst is synchronous and clears the input, result and sequence state.
module utf8_byte_stream_decoder_top (
  input  logic        clk,
  input  logic        rst,
  utf8d_byte_if.sink  bytes,
  utf8d_cp_if.source  code_points
);

  logic                          in_vld;
  logic [7:0]                    in_byte;
  logic                          in_last;
  logic [2:0]                    need;
  logic [utf8d_pkg::ACC_W-1:0]   acc;
  logic                          can_load;
  logic                          take;
  utf8d_pkg::decode_out_t        dec;

  assign take        = in_vld && can_load;
  assign bytes.ready = !in_vld || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      in_vld <= 1'b1;
    end else if (take) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_byte <= bytes.byte_in;
      in_last <= bytes.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      need <= 3'd0;
      acc  <= '0;
    end else if (take) begin
      need <= dec.need_next;
      acc  <= dec.acc_next;
    end
  end

  utf8d_decode u_decode (
    .byte_in   (in_byte),
    .last_byte (in_last),
    .need      (need),
    .acc       (acc),
    .dec       (dec)
  );

  utf8d_result_buf u_result_buf (
    .clk         (clk),
    .rst         (rst),
    .load        (in_vld),
    .count       (dec.count),
    .r0          (dec.r0),
    .r1          (dec.r1),
    .can_load    (can_load),
    .code_points (code_points)
  );

`ifndef SYNTHESIS
  a_last_closes_seq: assert property (@(posedge clk) disable iff (rst)
    take && in_last |=> need == 3'd0)
    else $error("sequence still open after last item");

  a_repl_value: assert property (@(posedge clk) disable iff (rst)
    code_points.valid && code_points.is_replacement |->
      code_points.code_point == utf8d_pkg::SUBST_CP)
    else $error("replacement flag without substitute value");

  a_pair_head: assert property (@(posedge clk) disable iff (rst)
    take && dec.count == 2'd2 |=> code_points.valid && !code_points.run_last)
    else $error("first of two results marked as final");
`endif

endmodule
